// ----- sv/orl_pkg.sv -----
// ----------------------------------------------------------------------------
// orl_pkg: shared types and constants for the ordered ring list engine
// Sizes, action and status codes, the cell control bundle and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package orl_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int FIELD_CNT_W = 5;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_ROTATE = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_APPEND = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } t_cell_op;

    // Broadcast to every cell in the row.
    typedef struct packed {
        t_cell_op                op;
        logic [CNT_W-1:0]        occ;
        logic [CNT_W-1:0]        last_idx;
        logic [DATA_WIDTH-1:0]   key;
    } t_cell_ctl;

    typedef struct packed {
        t_status                 status;
        logic [FIELD_CNT_W-1:0]  entry_count;
        logic [DATA_WIDTH-1:0]   element;
        logic                    element_valid;
        logic                    last;
    } t_result;

    // Zero-extend or truncate the occupancy to the 5-bit count field.
    function automatic logic [FIELD_CNT_W-1:0] cnt_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+FIELD_CNT_W-1:0] w;
        w = {{FIELD_CNT_W{1'b0}}, c};
        return w[FIELD_CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/orl_in_if.sv -----
// ----------------------------------------------------------------------------
// orl_in_if: input word channel
// Valid/ready channel carrying one action and its value.
// ----------------------------------------------------------------------------
`default_nettype none

interface orl_in_if;
    logic                                 valid;
    logic                                 ready;
    orl_pkg::t_action                     action;
    logic signed [orl_pkg::DATA_WIDTH-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ----- sv/orl_out_if.sv -----
// ----------------------------------------------------------------------------
// orl_out_if: result word channel
// Valid/ready channel carrying status, count and readout element.
// ----------------------------------------------------------------------------
`default_nettype none

interface orl_out_if;
    logic                                  valid;
    logic                                  ready;
    orl_pkg::t_status                      status;
    logic [orl_pkg::FIELD_CNT_W-1:0]       entry_count;
    logic signed [orl_pkg::DATA_WIDTH-1:0] element;
    logic                                  element_valid;
    logic                                  last;

    modport source (output valid, output status, output entry_count, output element,
                    output element_valid, output last, input ready);
    modport sink   (input valid, input status, input entry_count, input element,
                    input element_valid, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/orl_cell.sv -----
// ----------------------------------------------------------------------------
// orl_cell: one list position
// Holds one entry; loads from its right neighbor, the head or the key.
// ----------------------------------------------------------------------------
`default_nettype none

module orl_cell (
    input  wire logic                           i_clk,
    input  wire orl_pkg::t_cell_ctl             i_ctl,
    input  wire logic [orl_pkg::CNT_W-1:0]      i_index,
    input  wire logic [orl_pkg::DATA_WIDTH-1:0] i_next_data,
    input  wire logic [orl_pkg::DATA_WIDTH-1:0] i_head_data,
    input  wire logic                           i_found,
    output logic      [orl_pkg::DATA_WIDTH-1:0] o_data,
    output logic                                o_found
);

    logic [orl_pkg::DATA_WIDTH-1:0] r_data;
    logic [orl_pkg::DATA_WIDTH-1:0] n_data;
    logic                           w_live;
    logic                           w_match;

    assign w_live  = (i_index < i_ctl.occ);
    assign w_match = w_live && (r_data == i_ctl.key);
    assign o_found = i_found || w_match;
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            orl_pkg::OP_APPEND: begin
                if (i_index == i_ctl.occ) n_data = i_ctl.key;
            end
            orl_pkg::OP_DELETE: begin
                // close the gap behind the first match
                if (w_live && o_found) n_data = i_next_data;
            end
            orl_pkg::OP_ROTATE: begin
                if (i_index == i_ctl.last_idx) n_data = i_head_data;
                else if (i_index < i_ctl.last_idx) n_data = i_next_data;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire

// ----- sv/orl_chain.sv -----
// ----------------------------------------------------------------------------
// orl_chain: row of list cells
// Links each cell to its right neighbor and ripples the match flag from the head.
// ----------------------------------------------------------------------------
`default_nettype none

module orl_chain (
    input  wire logic                           i_clk,
    input  wire orl_pkg::t_cell_ctl             i_ctl,
    output logic      [orl_pkg::DATA_WIDTH-1:0] o_head,
    output logic                                o_found
);

    logic [orl_pkg::DATA_WIDTH-1:0] w_data  [orl_pkg::CAPACITY];
    logic [orl_pkg::DATA_WIDTH-1:0] w_next  [orl_pkg::CAPACITY];
    logic                           w_found [orl_pkg::CAPACITY+1];

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < orl_pkg::CAPACITY; g++) begin : g_cell
        if (g == orl_pkg::CAPACITY - 1) begin : g_tail
            assign w_next[g] = '0;
        end else begin : g_mid
            assign w_next[g] = w_data[g+1];
        end

        orl_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_index     (orl_pkg::CNT_W'(g)),
            .i_next_data (w_next[g]),
            .i_head_data (w_data[0]),
            .i_found     (w_found[g]),
            .o_data      (w_data[g]),
            .o_found     (w_found[g+1])
        );
    end

    assign o_head  = w_data[0];
    assign o_found = w_found[orl_pkg::CAPACITY];

endmodule

`default_nettype wire

// ----- sv/ordered_ring_list_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_ring_list_engine: bounded ordered circular list
// Append, delete first match, rotate and read out over a row of list cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, cell 0 being the head. For an
// append, delete or rotate, the input word is taken, the row updates at that
// edge and the single result word is loaded into the output register. An
// empty readout behaves the same way. A readout of a non-empty list emits one
// result word per entry from the read state: the row rotates one place per
// cycle while the output register is free and the head cell feeds each result
// word, so after the last word the list is back in its original order. No new
// input word is taken during a readout, and a consumer that holds off
// stretches it. The output register parts the two sides, so a new input word
// is taken while the previous result waits as long as the consumer takes that
// result in the same cycle. The store is not cleared at reset; the occupancy
// is, and cells at or above it never reach a match or a result.
`default_nettype none

module ordered_ring_list_engine (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    orl_in_if.sink    i_in,
    orl_out_if.source o_out
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                        r_state,     n_state;
    logic [orl_pkg::CNT_W-1:0]     r_occ,       n_occ;
    logic [orl_pkg::CNT_W-1:0]     r_rd_cnt,    n_rd_cnt;
    logic                          r_out_valid, n_out_valid;
    orl_pkg::t_result              r_out,       n_out;

    orl_pkg::t_cell_ctl            w_ctl;
    logic [orl_pkg::DATA_WIDTH-1:0] w_head;
    logic                          w_found;
    logic                          w_free;
    logic                          w_accept;

    orl_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .o_head  (w_head),
        .o_found (w_found)
    );

    // The output slot frees up when it is empty or being taken now.
    assign w_free     = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_free;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        orl_pkg::t_status st;
        st             = orl_pkg::ST_OK;
        n_state        = r_state;
        n_occ          = r_occ;
        n_rd_cnt       = r_rd_cnt;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out          = r_out;
        w_ctl.op       = orl_pkg::OP_HOLD;
        w_ctl.occ      = r_occ;
        w_ctl.last_idx = r_occ - orl_pkg::CNT_W'(1);
        w_ctl.key      = i_in.value;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.action)
                        orl_pkg::ACT_APPEND: begin
                            if (r_occ >= orl_pkg::CNT_W'(orl_pkg::CAPACITY)) begin
                                st = orl_pkg::ST_FULL;
                            end else begin
                                w_ctl.op = orl_pkg::OP_APPEND;
                                n_occ    = r_occ + orl_pkg::CNT_W'(1);
                            end
                        end
                        orl_pkg::ACT_DELETE: begin
                            if (r_occ == '0) begin
                                st = orl_pkg::ST_EMPTY;
                            end else if (w_found) begin
                                w_ctl.op = orl_pkg::OP_DELETE;
                                n_occ    = r_occ - orl_pkg::CNT_W'(1);
                            end else begin
                                st = orl_pkg::ST_NOT_FOUND;
                            end
                        end
                        orl_pkg::ACT_ROTATE: begin
                            if (r_occ == '0) st = orl_pkg::ST_EMPTY;
                            else w_ctl.op = orl_pkg::OP_ROTATE;
                        end
                        orl_pkg::ACT_READ: begin
                            if (r_occ == '0) begin
                                st = orl_pkg::ST_EMPTY;
                            end else begin
                                n_state  = S_READ;
                                n_rd_cnt = r_occ;
                            end
                        end
                        default: st = orl_pkg::ST_OK;
                    endcase

                    // a readout of a non-empty list emits from the read state
                    if (!(i_in.action == orl_pkg::ACT_READ && r_occ != '0)) begin
                        n_out_valid         = 1'b1;
                        n_out.status        = st;
                        n_out.entry_count   = orl_pkg::cnt_field(n_occ);
                        n_out.element       = '0;
                        n_out.element_valid = 1'b0;
                        n_out.last          = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (w_free) begin
                    // emit the head and advance the ring by one
                    w_ctl.op            = orl_pkg::OP_ROTATE;
                    n_out_valid         = 1'b1;
                    n_out.status        = orl_pkg::ST_OK;
                    n_out.entry_count   = orl_pkg::cnt_field(r_occ);
                    n_out.element       = w_head;
                    n_out.element_valid = 1'b1;
                    n_out.last          = (r_rd_cnt == orl_pkg::CNT_W'(1));
                    n_rd_cnt            = r_rd_cnt - orl_pkg::CNT_W'(1);
                    if (r_rd_cnt == orl_pkg::CNT_W'(1)) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_rd_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_rd_cnt    <= n_rd_cnt;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.entry_count   = r_out.entry_count;
    assign o_out.element       = r_out.element;
    assign o_out.element_valid = r_out.element_valid;
    assign o_out.last          = r_out.last;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= orl_pkg::CNT_W'(orl_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_read_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_rd_cnt != '0 && r_rd_cnt <= r_occ))
        else $error("readout count out of range");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.action == orl_pkg::ACT_APPEND
         && r_occ < orl_pkg::CNT_W'(orl_pkg::CAPACITY))
        |=> (r_occ == $past(r_occ) + orl_pkg::CNT_W'(1)))
        else $error("append did not grow the list");

    a_rotate_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.action == orl_pkg::ACT_ROTATE
                      || i_in.action == orl_pkg::ACT_READ)) |=> $stable(r_occ))
        else $error("rotate or readout changed occupancy");
`endif

endmodule

`default_nettype wire
